// ----- rtl/pps_pkg.sv -----
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants
// Item kinds, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_WAYPOINT = 2'd0;
   localparam kind_type KIND_POSE     = 2'd1;
   localparam kind_type KIND_COMPUTE  = 2'd2;

   typedef logic [1:0] reg_index_type;

   localparam reg_index_type REG_LOOKAHEAD = 2'd0;
   localparam reg_index_type REG_STOP      = 2'd1;
   localparam reg_index_type REG_WHEELBASE = 2'd2;

   typedef logic signed [17:0] angle_type;

   localparam angle_type ANG_PI      = 18'sd25736;
   localparam angle_type ANG_HALF_PI = 18'sd12868;

   localparam logic signed [63:0] SIN_GAIN_Q30 = 64'sd652032874;

   // atan(2^-i) in signed Q4.13
   localparam angle_type ATAN_TAB [32] = '{
      18'sd6434, 18'sd3798, 18'sd2007, 18'sd1019, 18'sd511, 18'sd256, 18'sd128,
      18'sd64, 18'sd32, 18'sd16, 18'sd8, 18'sd4, 18'sd2, 18'sd1, 18'sd0, 18'sd0,
      18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0,
      18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0
   };

endpackage

`default_nettype wire

// ----- rtl/pps_ram.sv -----
// ----------------------------------------------------------------------------
// pps_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ----- rtl/pure_pursuit_steering_top.sv -----
// ----------------------------------------------------------------------------
// pure_pursuit_steering_top: fixed-point pure-pursuit steering controller
// Waypoint table in RAM, shared integer square root and CORDIC unit.
// ----------------------------------------------------------------------------
// Use:
//  Items transfer at a clock edge with start high and busy low. A waypoint
//  item (kind 0) writes one table slot; wp_last sets the count and marks the
//  path loaded. A pose item (kind 1) stores position and quaternion. Both
//  take effect at that edge and leave busy low.
//  A compute item (kind 2), once path and pose exist, raises busy and later
//  gives one result on the rsp_ ports, marked by rsp_valid for one cycle.
//  The receiver cannot stall; the result is simply presented.
//  Path walk: each segment takes a RAM read, squaring of both parts and a
//  32-step root, up to the lookahead crossing. Then yaw, bearing, sine and
//  steering each use the CORDIC, and the target distance another root.
//  Walk cost is set by the bit-serial root and the single RAM read port.
//  csr_ writes land at once; issue them while busy is low.
//  Reset (synchronous) clears count, path and pose flags, the pose and the
//  registers to their defaults. The table RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module pure_pursuit_steering_top
   import pps_pkg::*;
#(
   parameter int MAX_WAYPOINTS = 256,
   parameter int CORDIC_STEPS  = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_kind,
   input  wire logic [7:0]         req_wp_index,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_wp_speed,
   input  wire logic               req_wp_last,
   input  wire logic signed [15:0] req_quat_w,
   input  wire logic signed [15:0] req_quat_x,
   input  wire logic signed [15:0] req_quat_y,
   input  wire logic signed [15:0] req_quat_z,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_speed_cmd,
   output logic signed [14:0]      rsp_steer_cmd,
   output logic                    rsp_stopped,
   output logic [7:0]              rsp_target_slot,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [30:0]        csr_wdata
);

   localparam int AW   = $clog2(MAX_WAYPOINTS);
   localparam int CNTW = AW + 1;
   localparam int CIW  = $clog2(CORDIC_STEPS);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_W0A   = 5'd1;
   localparam logic [4:0] S_W0    = 5'd2;
   localparam logic [4:0] S_WA    = 5'd3;
   localparam logic [4:0] S_WD    = 5'd4;
   localparam logic [4:0] S_DABS  = 5'd5;
   localparam logic [4:0] S_SQA   = 5'd6;
   localparam logic [4:0] S_SQB   = 5'd7;
   localparam logic [4:0] S_RT    = 5'd8;
   localparam logic [4:0] S_ACC   = 5'd9;
   localparam logic [4:0] S_TGW   = 5'd10;
   localparam logic [4:0] S_TGD   = 5'd11;
   localparam logic [4:0] S_CPRE  = 5'd12;
   localparam logic [4:0] S_CIT   = 5'd13;
   localparam logic [4:0] S_CDONE = 5'd14;
   localparam logic [4:0] S_FOLD  = 5'd15;
   localparam logic [4:0] S_LCHK  = 5'd16;
   localparam logic [4:0] S_MUL   = 5'd17;

   localparam logic [1:0] JOB_YAW = 2'd0;
   localparam logic [1:0] JOB_BRG = 2'd1;
   localparam logic [1:0] JOB_SIN = 2'd2;
   localparam logic [1:0] JOB_STR = 2'd3;

   logic [4:0] state_ff;

   // configuration and pose
   logic [30:0]        look_ff, stop_ff, wb_ff;
   logic signed [31:0] vx_ff, vy_ff;
   logic signed [15:0] qw_ff, qx_ff, qy_ff, qz_ff;
   logic               have_path_ff, have_pose_ff;
   logic [CNTW-1:0]    count_ff;

   // table RAM: {speed, y, x}
   logic               ram_we;
   logic [AW-1:0]      ram_waddr, addr_ff;
   logic [95:0]        ram_wdata, ram_rdata;

   // path walk
   logic [CNTW-1:0]    j_ff, tgt_ff;
   logic signed [31:0] px_ff, py_ff, cx_w, cy_w;
   logic [47:0]        sum_ff, sum_in;

   // distance unit
   logic signed [32:0] ddx_ff, ddy_ff;
   logic [32:0]        ax, bx;
   logic               big, sh_ff, dwalk_ff;
   logic [30:0]        da_ff, db_ff, mul_op;
   logic [61:0]        sq;
   logic [63:0]        rn_ff, rres_ff, rbit_ff, rtry;
   logic [32:0]        dval, l_ff;

   // target and angles
   logic signed [32:0] tdx_ff, tdy_ff;
   logic signed [31:0] tspd_ff;
   angle_type          yaw_ff;
   logic signed [19:0] alpha_ff;
   logic signed [32:0] sn_ff;
   logic signed [64:0] prod;
   logic signed [31:0] pwz, pxy, pyy, pzz;

   // CORDIC
   logic signed [63:0] ccx_ff, ccy_ff, xs, ys;
   angle_type          ccz_ff, at;
   logic [CIW-1:0]     ci_ff;
   logic [1:0]         job_ff;
   logic               cvec_ff, cw;

   logic               acc_cmp, acc_wp, acc_pose, acc_go;
   logic               rsp_valid_ff, rsp_stopped_ff;
   logic signed [31:0] rsp_speed_ff;
   logic signed [14:0] rsp_steer_ff;
   logic [7:0]         rsp_slot_ff;

   assign busy     = (state_ff != S_IDLE);
   assign acc_wp   = start && !busy && (req_kind == KIND_WAYPOINT) &&
                     (32'(req_wp_index) < MAX_WAYPOINTS);
   assign acc_pose = start && !busy && (req_kind == KIND_POSE);
   assign acc_cmp  = start && !busy && (req_kind == KIND_COMPUTE);
   assign acc_go   = acc_cmp && have_path_ff && have_pose_ff && (count_ff != '0);

   // writes are only taken while idle, so no read of the same slot can overlap
   assign ram_we    = acc_wp;
   assign ram_waddr = AW'(req_wp_index);
   assign ram_wdata = {req_wp_speed, req_pos_y, req_pos_x};

   pps_ram #(.WIDTH(96), .DEPTH(MAX_WAYPOINTS)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   assign cx_w = ram_rdata[31:0];
   assign cy_w = ram_rdata[63:32];

   // distance prep: abs, halve if either part reaches 2^31
   assign ax  = ddx_ff[32] ? 33'(-ddx_ff) : 33'(ddx_ff);
   assign bx  = ddy_ff[32] ? 33'(-ddy_ff) : 33'(ddy_ff);
   assign big = ax[32] | ax[31] | bx[32] | bx[31];

   assign mul_op = (state_ff == S_SQA) ? da_ff : db_ff;
   assign sq     = mul_op * mul_op;
   assign rtry   = rres_ff + rbit_ff;
   assign dval   = sh_ff ? {rres_ff[31:0], 1'b0} : {1'b0, rres_ff[31:0]};
   assign sum_in = sum_ff + 48'(dval);

   assign pwz = qw_ff * qz_ff;
   assign pxy = qx_ff * qy_ff;
   assign pyy = qy_ff * qy_ff;
   assign pzz = qz_ff * qz_ff;

   assign prod = $signed({1'b0, wb_ff}) * sn_ff;

   assign xs = ccx_ff >>> ci_ff;
   assign ys = ccy_ff >>> ci_ff;
   assign at = ATAN_TAB[5'(ci_ff)];
   // vectoring turns toward y = 0, rotation toward z = 0
   assign cw = cvec_ff ? (ccy_ff > 0) : ccz_ff[17];

   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      if (reset) begin
         state_ff     <= S_IDLE;
         look_ff      <= 31'd393216;
         stop_ff      <= 31'd163840;
         wb_ff        <= 31'd122421;
         vx_ff        <= '0;
         vy_ff        <= '0;
         qw_ff        <= 16'sd32767;
         qx_ff        <= '0;
         qy_ff        <= '0;
         qz_ff        <= '0;
         have_path_ff <= 1'b0;
         have_pose_ff <= 1'b0;
         count_ff     <= '0;
         addr_ff      <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_LOOKAHEAD: look_ff <= csr_wdata;
               REG_STOP:      stop_ff <= csr_wdata;
               REG_WHEELBASE: wb_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (acc_wp && req_wp_last) begin
            count_ff     <= CNTW'(req_wp_index) + CNTW'(1);
            have_path_ff <= 1'b1;
         end
         if (acc_pose) begin
            vx_ff        <= req_pos_x;
            vy_ff        <= req_pos_y;
            qw_ff        <= req_quat_w;
            qx_ff        <= req_quat_x;
            qy_ff        <= req_quat_y;
            qz_ff        <= req_quat_z;
            have_pose_ff <= 1'b1;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (acc_go) begin
                  addr_ff  <= '0;
                  sum_ff   <= '0;
                  tgt_ff   <= count_ff - CNTW'(1);
                  state_ff <= S_W0A;
               end
            end
            S_W0A: state_ff <= S_W0;
            S_W0: begin
               px_ff <= cx_w;
               py_ff <= cy_w;
               j_ff  <= CNTW'(1);
               if (count_ff > CNTW'(1)) begin
                  addr_ff  <= AW'(1);
                  state_ff <= S_WA;
               end else begin
                  addr_ff  <= AW'(tgt_ff);
                  state_ff <= S_TGW;
               end
            end
            S_WA: state_ff <= S_WD;
            S_WD: begin
               ddx_ff   <= 33'(cx_w) - 33'(px_ff);
               ddy_ff   <= 33'(cy_w) - 33'(py_ff);
               px_ff    <= cx_w;
               py_ff    <= cy_w;
               dwalk_ff <= 1'b1;
               state_ff <= S_DABS;
            end
            S_DABS: begin
               sh_ff    <= big;
               da_ff    <= big ? ax[31:1] : ax[30:0];
               db_ff    <= big ? bx[31:1] : bx[30:0];
               state_ff <= S_SQA;
            end
            S_SQA: begin
               rn_ff    <= 64'(sq);
               state_ff <= S_SQB;
            end
            S_SQB: begin
               rn_ff    <= rn_ff + 64'(sq);
               rres_ff  <= '0;
               rbit_ff  <= 64'd1 << 62;
               state_ff <= S_RT;
            end
            S_RT: begin
               if (rn_ff >= rtry) begin
                  rn_ff   <= rn_ff - rtry;
                  rres_ff <= (rres_ff >> 1) + rbit_ff;
               end else begin
                  rres_ff <= rres_ff >> 1;
               end
               rbit_ff <= rbit_ff >> 2;
               if (rbit_ff == 64'd1) begin
                  state_ff <= dwalk_ff ? S_ACC : S_LCHK;
               end
            end
            S_ACC: begin
               sum_ff <= sum_in;
               if (sum_in > 48'(look_ff)) begin
                  tgt_ff   <= j_ff;
                  addr_ff  <= AW'(j_ff);
                  state_ff <= S_TGW;
               end else if (j_ff + CNTW'(1) < count_ff) begin
                  j_ff     <= j_ff + CNTW'(1);
                  addr_ff  <= AW'(j_ff + CNTW'(1));
                  state_ff <= S_WA;
               end else begin
                  addr_ff  <= AW'(tgt_ff);
                  state_ff <= S_TGW;
               end
            end
            S_TGW: state_ff <= S_TGD;
            S_TGD: begin
               tdx_ff   <= 33'(cx_w) - 33'(vx_ff);
               tdy_ff   <= 33'(cy_w) - 33'(vy_ff);
               tspd_ff  <= ram_rdata[95:64];
               ccy_ff   <= (64'(pwz) + 64'(pxy)) <<< 1;
               ccx_ff   <= (64'sd1 <<< 30) - ((64'(pyy) + 64'(pzz)) <<< 1);
               cvec_ff  <= 1'b1;
               job_ff   <= JOB_YAW;
               state_ff <= S_CPRE;
            end
            S_CPRE: begin
               ci_ff <= '0;
               if (ccx_ff == 0 && ccy_ff == 0) begin
                  ccz_ff   <= '0;
                  state_ff <= S_CDONE;
               end else if (ccx_ff < 0) begin
                  ccz_ff   <= (ccy_ff >= 0) ? ANG_PI : -ANG_PI;
                  ccx_ff   <= -ccx_ff;
                  ccy_ff   <= -ccy_ff;
                  state_ff <= (ccy_ff == 0) ? S_CDONE : S_CIT;
               end else begin
                  ccz_ff   <= '0;
                  state_ff <= (ccy_ff == 0) ? S_CDONE : S_CIT;
               end
            end
            S_CIT: begin
               if (cw) begin
                  ccx_ff <= ccx_ff + ys;
                  ccy_ff <= ccy_ff - xs;
                  ccz_ff <= ccz_ff + at;
               end else begin
                  ccx_ff <= ccx_ff - ys;
                  ccy_ff <= ccy_ff + xs;
                  ccz_ff <= ccz_ff - at;
               end
               ci_ff <= ci_ff + CIW'(1);
               if (ci_ff == CIW'(CORDIC_STEPS - 1)) begin
                  state_ff <= S_CDONE;
               end
            end
            S_CDONE: begin
               unique case (job_ff)
                  JOB_YAW: begin
                     yaw_ff   <= ccz_ff;
                     ccx_ff   <= 64'(tdx_ff);
                     ccy_ff   <= 64'(tdy_ff);
                     job_ff   <= JOB_BRG;
                     state_ff <= S_CPRE;
                  end
                  JOB_BRG: begin
                     alpha_ff <= 20'(ccz_ff) - 20'(yaw_ff);
                     state_ff <= S_FOLD;
                  end
                  JOB_SIN: begin
                     sn_ff    <= ccy_ff[32:0];
                     state_ff <= S_MUL;
                  end
                  JOB_STR: begin
                     rsp_valid_ff   <= 1'b1;
                     rsp_stopped_ff <= 1'b0;
                     rsp_speed_ff   <= tspd_ff;
                     rsp_slot_ff    <= 8'(tgt_ff);
                     priority if (ccz_ff > ANG_HALF_PI) begin
                        rsp_steer_ff <= 15'(ANG_HALF_PI);
                     end else if (ccz_ff < -ANG_HALF_PI) begin
                        rsp_steer_ff <= 15'(-ANG_HALF_PI);
                     end else begin
                        rsp_steer_ff <= 15'(ccz_ff);
                     end
                     state_ff <= S_IDLE;
                  end
                  default: ;
               endcase
            end
            S_FOLD: begin
               // one step of pi per cycle
               priority if (alpha_ff > 20'(ANG_HALF_PI)) begin
                  alpha_ff <= alpha_ff - 20'(ANG_PI);
               end else if (alpha_ff < -20'(ANG_HALF_PI)) begin
                  alpha_ff <= alpha_ff + 20'(ANG_PI);
               end else begin
                  ddx_ff   <= tdx_ff;
                  ddy_ff   <= tdy_ff;
                  dwalk_ff <= 1'b0;
                  state_ff <= S_DABS;
               end
            end
            S_LCHK: begin
               l_ff <= dval;
               if (dval > 33'(stop_ff)) begin
                  ccx_ff   <= SIN_GAIN_Q30;
                  ccy_ff   <= '0;
                  ccz_ff   <= 18'(alpha_ff);
                  ci_ff    <= '0;
                  cvec_ff  <= 1'b0;
                  job_ff   <= JOB_SIN;
                  state_ff <= S_CIT;
               end else begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_stopped_ff <= 1'b1;
                  rsp_speed_ff   <= '0;
                  rsp_steer_ff   <= '0;
                  rsp_slot_ff    <= 8'(tgt_ff);
                  state_ff       <= S_IDLE;
               end
            end
            S_MUL: begin
               // 2*wheelbase*sin >> 15, against l << 15
               ccy_ff   <= 64'(prod >>> 14);
               ccx_ff   <= {16'b0, l_ff, 15'b0};
               cvec_ff  <= 1'b1;
               job_ff   <= JOB_STR;
               state_ff <= S_CPRE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_speed_cmd   = rsp_speed_ff;
   assign rsp_steer_cmd   = rsp_steer_ff;
   assign rsp_stopped     = rsp_stopped_ff;
   assign rsp_target_slot = rsp_slot_ff;

`ifndef SYNTHESIS
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held two cycles");
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stopped |-> rsp_speed_cmd == 0 && rsp_steer_cmd == 0)
      else $error("stopped result carries a command");
   a_steer_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_steer_cmd <= 15'sd12868 && rsp_steer_cmd >= -15'sd12868)
      else $error("steering out of range");
   a_go_busy: assert property (@(posedge clock) disable iff (reset)
      acc_go |=> busy) else $error("compute transfer did not start work");
`endif

endmodule

`default_nettype wire
